[hdl/fmv_pkg.sv]
// Shared types, constants and table-building functions of the FM voice sample generator.
`default_nettype none
package fmv_pkg;

  // Command codes carried in the request kind
  typedef enum logic [1:0] {
    CMD_RESET   = 2'd0,
    CMD_NOTE_ON = 2'd1,
    CMD_RENDER  = 2'd2
  } cmd_t;

  // One classified request as it sits in the queue
  typedef struct packed {
    cmd_t               cmd;
    logic [3:0]         voice;
    logic [6:0]         note;
    logic signed [14:0] pitch;
    logic [15:0]        ratio;
    logic [15:0]        index;
    logic [6:0]         count;
  } req_t;

  // Phase increments of one render request
  typedef struct packed {
    logic [31:0] cstep;
    logic [31:0] mstep;
    logic [31:0] tstep;
  } steps_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OCT, ST_MANT, ST_SCALE, ST_DIV, ST_SHIFT, ST_MUL0, ST_MUL1, ST_DONE
  } step_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_READ, B_LOAD, B_STEP, B_MOD, B_PM, B_OFF, B_CAR, B_THR,
    B_MIXA, B_MIXB, B_EMIT, B_WB
  } back_state_t;

  localparam int          MAX_SAMPLES = 64;
  localparam int          QDEPTH      = 2;
  localparam int          PITCH_BIAS  = 19200;   // 36864 - 69*256
  localparam int          SEMI_OCT    = 3072;    // 1/256 semitones per octave
  localparam int          OCT_BIAS    = 10;
  localparam int          BASE_HZ     = 440;
  localparam int          MIX_MAIN    = 22938;   // 0.7 in Q15
  localparam int          MIX_THIRD   = 9830;    // 0.3 in Q15
  localparam longint      INV_TWO_PI  = 64'd683565276;
  localparam longint      TWO_PI_Q30  = 64'd6746518852;
  localparam longint      Q30_ONE     = 64'd1 << 30;
  localparam logic [17:0] RATE_RESET  = 18'd48000;

  function automatic longint unsigned cube_q30(input longint unsigned x);
    longint unsigned s;
    s = (x * x) >> 30;
    return (s * x) >> 30;
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v_in);
    longint unsigned v, r, bit_w;
    v = v_in;
    r = 0;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_w > v) bit_w = bit_w >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_w != 0) begin
        if (v >= r + bit_w) begin
          v = v - (r + bit_w);
          r = (r >> 1) + bit_w;
        end else begin
          r = r >> 1;
        end
        bit_w = bit_w >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^b/3072) in Q30
  function automatic longint unsigned root_q30(input int b);
    longint unsigned lo, hi, mid, cur;
    lo = Q30_ONE;
    hi = (Q30_ONE << 1) - 1;
    for (int i = 0; i < 64; i++) begin
      if (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (cube_q30(mid) <= (Q30_ONE << 1)) lo = mid;
        else hi = mid - 1;
      end
    end
    cur = lo;
    if (b == 11) cur = (lo * lo) >> 30;
    for (int bb = 9; bb >= 0; bb--) begin
      if (bb >= b) cur = isqrt64(cur << 30);
    end
    return cur;
  endfunction

  function automatic longint unsigned sin_q30(input longint unsigned x);
    longint unsigned x2, t, a;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    for (int i = 0; i < 5; i++) begin
      a = (x2 * t) >> 30;
      case (i)
        0:       t = Q30_ONE - a / 64'd110;
        1:       t = Q30_ONE - a / 64'd72;
        2:       t = Q30_ONE - a / 64'd42;
        3:       t = Q30_ONE - a / 64'd20;
        default: t = Q30_ONE - a / 64'd6;
      endcase
    end
    return (x * t) >> 30;
  endfunction

  // Sine table entry k of a 2^bits table, Q15
  function automatic int sine_entry(input int bits, input int k);
    longint unsigned quarter, qd, j, jj, x;
    int v;
    quarter = (64'd1 << bits) >> 2;
    qd = longint'(k) >> (bits - 2);
    j = longint'(k) & (quarter - 1);
    jj = qd[0] ? quarter - j : j;
    x = (jj * TWO_PI_Q30) >> bits;
    v = int'((sin_q30(x) + 16384) >> 15);
    return qd[1] ? -v : v;
  endfunction

endpackage
`default_nettype wire

[hdl/fmv_front.sv]
// Front end: classifies incoming requests and drops those that do nothing.
`default_nettype none
module fmv_front #(
  parameter int MAX_VOICES = 16
) (
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_cmd,
  input  wire logic [3:0]    in_voice,
  input  wire logic [6:0]    in_note,
  input  wire logic [14:0]   in_pitch,
  input  wire logic [15:0]   in_ratio,
  input  wire logic [15:0]   in_index,
  input  wire logic [6:0]    in_count,
  input  wire logic          q_full,
  output logic               in_ready,
  output logic               push,
  output fmv_pkg::req_t      item
);
  import fmv_pkg::*;

  logic voice_ok;
  logic keep;

  assign in_ready = !q_full;
  assign voice_ok = {5'd0, in_voice} < 9'(MAX_VOICES);

  // Keep reset always; note on only for a real voice, render only for a real voice and a nonzero count
  always_comb begin
    keep = 1'b0;
    case (in_cmd)
      CMD_RESET:   keep = 1'b1;
      CMD_NOTE_ON: keep = voice_ok;
      CMD_RENDER:  keep = voice_ok && (in_count != 7'd0);
      default:     keep = 1'b0;
    endcase
  end

  assign push = in_valid && in_ready && keep;

  always_comb begin
    item.cmd   = cmd_t'(in_cmd);
    item.voice = in_voice;
    item.note  = in_note;
    item.pitch = $signed(in_pitch);
    item.ratio = in_ratio;
    item.index = in_index;
    item.count = (in_count > 7'(MAX_SAMPLES)) ? 7'(MAX_SAMPLES) : in_count;
  end

endmodule
`default_nettype wire

[hdl/fmv_queue.sv]
// Short request queue between front and back.
`default_nettype none
module fmv_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fmv_pkg::req_t push_item,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output fmv_pkg::req_t      head
);
  import fmv_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  req_t            slots [QDEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     fill;

  assign full      = fill == (PW+1)'(QDEPTH);
  assign not_empty = fill != '0;
  assign head      = slots[rptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_item;
  end

endmodule
`default_nettype wire

[hdl/fmv_step.sv]
// Phase-step unit: note and pitch to carrier, modulator and third increments.
`default_nettype none
module fmv_step (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [6:0]         note,
  input  wire logic signed [14:0] pitch,
  input  wire logic [15:0]        ratio,
  input  wire logic [17:0]        sample_rate,
  output logic                    done,
  output fmv_pkg::steps_t         steps
);
  import fmv_pkg::*;

  step_state_t state, state_next;
  logic [16:0] u;
  logic [4:0]  oct;
  logic [3:0]  bidx;
  logic [30:0] m;
  logic [52:0] dvd;
  logic [17:0] rem;
  logic [5:0]  cnt;
  logic [3:0]  sh;
  logic [44:0] low;
  logic [60:0] prod;
  logic [15:0] ratio_r;
  logic [30:0] root [12];
  logic [17:0] divisor;
  logic [18:0] rem_sh;
  logic [39:0] t;
  logic [61:0] mprod;
  logic signed [17:0] u_start;

  for (genvar b = 0; b < 12; b++) begin : g_root
    assign root[b] = 31'(root_q30(b));
  end

  assign divisor = (sample_rate == '0) ? 18'd1 : sample_rate;
  assign rem_sh  = {rem, dvd[52]};
  assign t       = 40'(BASE_HZ) * 40'(m);
  assign mprod   = 62'(m) * 62'(root[bidx]);
  assign u_start = $signed({1'b0, note, 8'd0}) + 18'(pitch) + 18'sd19200;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    done = 1'b0;
    case (state)
      ST_IDLE:  if (start) state_next = ST_OCT;
      ST_OCT:   if (u < 17'(SEMI_OCT)) state_next = ST_MANT;
      ST_MANT:  if (bidx == 4'd11) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_DIV;
      ST_DIV:   if (cnt == 6'd1) state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_MUL0;
      ST_MUL0:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_DONE;
      ST_DONE: begin
        done = 1'b1;
        state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Datapath: octave by subtraction, mantissa by roots, long division, ratio product
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        u <= 17'(u_start);
        oct <= '0;
        bidx <= '0;
        m <= 31'(Q30_ONE);
        ratio_r <= ratio;
      end
      ST_OCT: begin
        if (u >= 17'(SEMI_OCT)) begin
          u <= u - 17'(SEMI_OCT);
          oct <= oct + 1'b1;
        end
      end
      ST_MANT: begin
        if (u[bidx]) m <= mprod[60:30];
        bidx <= bidx + 1'b1;
      end
      ST_SCALE: begin
        rem <= '0;
        cnt <= 6'd53;
        if (oct >= 5'(OCT_BIAS)) begin
          dvd <= 53'(t) << (oct - 5'(OCT_BIAS));
          sh <= '0;
        end else begin
          dvd <= 53'(t);
          sh <= 4'(5'(OCT_BIAS) - oct);
        end
      end
      ST_DIV: begin
        cnt <= cnt - 1'b1;
        if (rem_sh >= {1'b0, divisor}) begin
          rem <= 18'(rem_sh - {1'b0, divisor});
          dvd <= {dvd[51:0], 1'b1};
        end else begin
          rem <= rem_sh[17:0];
          dvd <= {dvd[51:0], 1'b0};
        end
      end
      ST_SHIFT: low <= 45'(dvd >> sh);
      ST_MUL0:  prod <= 61'(low[21:0]) * 61'(ratio_r);
      ST_MUL1:  prod <= prod + ((61'(low[44:22]) * 61'(ratio_r)) << 22);
      default: ;
    endcase
  end

  assign steps.cstep = low[31:0];
  assign steps.mstep = prod[43:12];
  assign steps.tstep = prod[44:13];

endmodule
`default_nettype wire

[hdl/fmv_back.sv]
// Back end: voice store, sine table and the per-sample FM sequencer with output register.
`default_nettype none
module fmv_back #(
  parameter int MAX_VOICES      = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire fmv_pkg::req_t q_item,
  output logic               q_pop,
  input  wire logic [17:0]   sample_rate,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [15:0]        out_sample,
  output logic               out_last
);
  import fmv_pkg::*;

  localparam int NV    = (MAX_VOICES < 16) ? MAX_VOICES : 16;
  localparam int AW    = (NV > 1) ? $clog2(NV) : 1;
  localparam int TAB_N = 1 << SINE_TABLE_BITS;
  localparam int TB    = SINE_TABLE_BITS;

  back_state_t state, state_next;
  req_t        cur;
  logic [NV-1:0] active;

  // Voice store
  logic [6:0]  note_mem [NV];
  logic [31:0] cph_mem  [NV];
  logic [31:0] mph_mem  [NV];
  logic [31:0] tph_mem  [NV];
  logic [6:0]  rd_note;
  logic [31:0] rd_c, rd_m, rd_t;
  logic [AW-1:0] qaddr, caddr;

  // Working registers
  logic [31:0] cph, mph, tph;
  steps_t      stp;
  logic [6:0]  n;
  logic signed [33:0] p;
  logic [31:0] offm;
  logic        pneg;
  logic signed [16:0] car, thr;
  logic signed [31:0] macc;
  logic signed [32:0] mix;

  // Sine table
  logic signed [16:0] rom [TAB_N];
  logic [TB-1:0]      rom_addr;
  logic signed [16:0] rom_q;
  logic [31:0]        car_ph;

  logic        step_start, step_done;
  steps_t      step_out;
  logic        note_we, ph_we, wb;
  logic [32:0] mag;
  logic signed [33:0] rnd;
  logic signed [15:0] sat;
  logic        emit;

  for (genvar k = 0; k < TAB_N; k++) begin : g_rom
    assign rom[k] = 17'(sine_entry(SINE_TABLE_BITS, k));
  end

  assign qaddr  = q_item.voice[AW-1:0];
  assign caddr  = cur.voice[AW-1:0];
  assign car_ph = cph + (pneg ? (32'd0 - offm) : offm);

  // Table address select
  always_comb begin
    case (state)
      B_CAR:   rom_addr = car_ph[31 -: TB];
      B_THR:   rom_addr = tph[31 -: TB];
      default: rom_addr = mph[31 -: TB];
    endcase
  end

  always_ff @(posedge clk) begin
    rom_q <= rom[rom_addr];
  end

  fmv_step u_step (
    .clk         (clk),
    .rst         (rst),
    .start       (step_start),
    .note        (rd_note),
    .pitch       (cur.pitch),
    .ratio       (cur.ratio),
    .sample_rate (sample_rate),
    .done        (step_done),
    .steps       (step_out)
  );

  // Memory writes: note on zeroes phases, end of render writes them back
  assign note_we = q_pop && (q_item.cmd == CMD_NOTE_ON);
  assign wb      = state == B_WB;
  assign ph_we   = note_we || wb;

  always_ff @(posedge clk) begin
    if (note_we) note_mem[qaddr] <= q_item.note;
    if (ph_we) begin
      cph_mem[wb ? caddr : qaddr] <= wb ? cph : '0;
      mph_mem[wb ? caddr : qaddr] <= wb ? mph : '0;
      tph_mem[wb ? caddr : qaddr] <= wb ? tph : '0;
    end
    rd_note <= note_mem[caddr];
    rd_c    <= cph_mem[caddr];
    rd_m    <= mph_mem[caddr];
    rd_t    <= tph_mem[caddr];
  end

  // Rounding and saturation of the mix
  assign rnd = ($signed({mix[32], mix}) + 34'sd16384) >>> 15;
  assign sat = (rnd > 34'sd32767) ? 16'sh7fff :
               (rnd < -34'sd32768) ? 16'sh8000 : 16'(rnd);
  assign emit = (state == B_EMIT) && (!out_valid || out_ready);
  assign mag  = p[33] ? 33'(-p) : 33'(p);

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    step_start = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.cmd == CMD_RENDER && active[qaddr]) state_next = B_READ;
        end
      end
      B_READ: state_next = B_LOAD;
      B_LOAD: begin
        step_start = 1'b1;
        state_next = B_STEP;
      end
      B_STEP: if (step_done) state_next = B_MOD;
      B_MOD:  state_next = B_PM;
      B_PM:   state_next = B_OFF;
      B_OFF:  state_next = B_CAR;
      B_CAR:  state_next = B_THR;
      B_THR:  state_next = B_MIXA;
      B_MIXA: state_next = B_MIXB;
      B_MIXB: state_next = B_EMIT;
      B_EMIT: begin
        if (emit) state_next = (n + 1'b1 == cur.count) ? B_WB : B_MOD;
      end
      B_WB:   state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Active flags
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (q_pop) begin
      if (q_item.cmd == CMD_RESET) active <= '0;
      else if (q_item.cmd == CMD_NOTE_ON) active[qaddr] <= 1'b1;
    end
  end

  // Sample datapath
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
    case (state)
      B_LOAD: begin
        cph <= rd_c;
        mph <= rd_m;
        tph <= rd_t;
      end
      B_STEP: begin
        stp <= step_out;
        n <= '0;
      end
      B_PM:   p <= 34'(rom_q) * 34'($signed({1'b0, cur.index}));
      B_OFF: begin
        pneg <= p[33];
        offm <= 32'((64'(mag[31:0]) * INV_TWO_PI) >> 27);
      end
      B_THR:  car <= rom_q;
      B_MIXA: begin
        macc <= 32'(car) * 32'(MIX_MAIN);
        thr <= rom_q;
      end
      B_MIXB: mix <= 33'(macc) + 33'(thr) * 33'(MIX_THIRD);
      B_EMIT: begin
        if (emit) begin
          cph <= cph + stp.cstep;
          mph <= mph + stp.mstep;
          tph <= tph + stp.tstep;
          n <= n + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample <= sat;
      out_last <= (n + 1'b1 == cur.count);
    end
  end

endmodule
`default_nettype wire

[hdl/fm_voice_sample_generator.sv]
// Top level of the FM voice sample generator.
`default_nettype none
// Two-operator FM voice bank with a third sine partial. Requests arrive with
// their command in s_axis_tuser; reset and note-on give no output. A render on
// an active voice first works out the phase steps in a shared sequencer (octave
// by repeated subtraction, mantissa by roots, bit-serial division by the sample
// rate, then the final shift and ratio product), then works through its samples
// one at a time, each with three lookups of the single-port sine table and the
// mix multiplies. A two-entry request queue lets new requests in while a render
// runs, and samples leave through an output register. sample_rate is written
// through cfg_we/cfg_wdata; the user must write it only while idle, as the block
// itself does not enforce this.
module fm_voice_sample_generator #(
  parameter int MAX_VOICES      = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [17:0] cfg_wdata,      // sample_rate
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // voice[3:0], note_number[10:4], pitch_offset[25:11], fm_ratio[41:26],
  // fm_index[57:42], sample_count[64:58], zero fill
  input  wire logic [71:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // sample[15:0]
  output logic             m_axis_tlast
);
  import fmv_pkg::*;

  logic [17:0] sample_rate;
  logic        push, q_full, q_valid, q_pop;
  req_t        item, head;

  // Sample rate register
  always_ff @(posedge clk) begin
    if (rst) sample_rate <= RATE_RESET;
    else if (cfg_we) sample_rate <= cfg_wdata;
  end

  fmv_front #(.MAX_VOICES(MAX_VOICES)) u_front (
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_voice (s_axis_tdata[3:0]),
    .in_note  (s_axis_tdata[10:4]),
    .in_pitch (s_axis_tdata[25:11]),
    .in_ratio (s_axis_tdata[41:26]),
    .in_index (s_axis_tdata[57:42]),
    .in_count (s_axis_tdata[64:58]),
    .q_full   (q_full),
    .in_ready (s_axis_tready),
    .push     (push),
    .item     (item)
  );

  fmv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  fmv_back #(
    .MAX_VOICES      (MAX_VOICES),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (head),
    .q_pop       (q_pop),
    .sample_rate (sample_rate),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_sample  (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the FM voice sample generator: random and directed requests.
`default_nettype none
module testbench;
  import fmv_pkg::*;

  localparam int VOICES     = 16;
  localparam int TAB_BITS   = 10;
  localparam int STALL_LEN  = 2000;
  localparam int DRAIN_WAIT = 800;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;   // command code with no meaning

  typedef struct {
    logic [15:0] sample;
    logic        last;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [17:0] cfg_wdata = RATE_RESET;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = CMD_RESET;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  fm_voice_sample_generator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shared state between processes
  req_t        pending_reqs[$];
  sample_t     expected_samples[$];
  req_t        cur_req;
  logic        req_taken = 1'b0;
  logic        quiet = 1'b0;
  logic        hold_off_req = 1'b0;
  int          failures = 0;

  // Predictor state
  int              sine_tab[1 << TAB_BITS];
  longint unsigned root_tab[12];
  logic [17:0]     rate_reg = RATE_RESET;
  logic            voice_on[VOICES];
  logic [6:0]      voice_key[VOICES];
  logic [31:0]     car_ph[VOICES];
  logic [31:0]     mod_ph[VOICES];
  logic [31:0]     thr_ph[VOICES];

  function automatic longint unsigned cubed(input longint unsigned x);
    longint unsigned s;
    s = (x * x) >> 30;
    return (s * x) >> 30;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Quarter-wave sine by truncated Taylor series, Q30 in and out
  function automatic longint unsigned taylor_sin(input longint unsigned x);
    longint unsigned divs[5];
    longint unsigned x2, t;
    divs = '{110, 72, 42, 20, 6};
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    for (int i = 0; i < 5; i++) t = Q30_ONE - ((x2 * t) >> 30) / divs[i];
    return (x * t) >> 30;
  endfunction

  task automatic build_tables();
    longint unsigned lo, hi, mid, jj, x;
    int unsigned quarter, qd, j;
    int v;
    lo = Q30_ONE;
    hi = (Q30_ONE << 1) - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (cubed(mid) <= (Q30_ONE << 1)) lo = mid;
      else hi = mid - 1;
    end
    root_tab[10] = lo;
    root_tab[11] = (lo * lo) >> 30;
    for (int b = 9; b >= 0; b--) root_tab[b] = int_sqrt(root_tab[b + 1] << 30);
    quarter = (1 << TAB_BITS) >> 2;
    for (int k = 0; k < (1 << TAB_BITS); k++) begin
      qd = k >> (TAB_BITS - 2);
      j = k & (quarter - 1);
      jj = qd[0] ? quarter - j : j;
      x = (jj * TWO_PI_Q30) >> TAB_BITS;
      v = int'((taylor_sin(x) + 16384) >> 15);
      sine_tab[k] = qd[1] ? -v : v;
    end
  endtask

  // Full carrier phase step for a note and pitch shift at the current rate
  function automatic longint unsigned carrier_step(input logic [6:0] key,
                                                   input logic signed [14:0] bend);
    int s, e;
    int unsigned u, frac;
    longint unsigned m, t, sr;
    s = (int'(key) - 69) * 256 + int'(bend);
    u = s + 36864;
    e = int'(u / 3072) - 10;
    frac = u % 3072;
    m = Q30_ONE;
    for (int b = 0; b < 12; b++) if (frac[b]) m = (m * root_tab[b]) >> 30;
    t = 440 * m;
    sr = (rate_reg == 0) ? 1 : rate_reg;
    if (e >= 0) return (t << e) / sr;
    return (t / sr) >> (-e);
  endfunction

  // Apply one request to the voice bank and queue the samples it yields
  task automatic predict_request(input req_t r);
    longint unsigned q, low, mag, cstep, mstep, tstep;
    longint p, mix, y;
    logic [31:0] off;
    int n, car, thr;
    sample_t smp;
    if (r.cmd == CMD_RESET) begin
      foreach (voice_on[i]) voice_on[i] = 1'b0;
    end else if (r.cmd == CMD_NOTE_ON) begin
      voice_on[r.voice] = 1'b1;
      voice_key[r.voice] = r.note;
      car_ph[r.voice] = '0;
      mod_ph[r.voice] = '0;
      thr_ph[r.voice] = '0;
    end else if (r.cmd == CMD_RENDER && voice_on[r.voice] && r.count != 0) begin
      n = (r.count > MAX_SAMPLES) ? MAX_SAMPLES : r.count;
      q = carrier_step(voice_key[r.voice], r.pitch);
      low = q & ((64'd1 << 45) - 1);
      cstep = q & 64'hFFFF_FFFF;
      mstep = ((low * r.ratio) >> 12) & 64'hFFFF_FFFF;
      tstep = ((low * r.ratio) >> 13) & 64'hFFFF_FFFF;
      for (int i = 0; i < n; i++) begin
        p = longint'(sine_tab[mod_ph[r.voice][31:22]]) * longint'(r.index);
        mag = (p < 0) ? -p : p;
        off = 32'((mag * INV_TWO_PI) >> 27);
        if (p < 0) off = -off;
        car = sine_tab[(car_ph[r.voice] + off) >> 22];
        thr = sine_tab[thr_ph[r.voice][31:22]];
        mix = longint'(car) * MIX_MAIN + longint'(thr) * MIX_THIRD;
        y = (mix + 16384) >>> 15;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        smp.sample = y[15:0];
        smp.last = (i == n - 1);
        expected_samples.push_back(smp);
        car_ph[r.voice] += cstep[31:0];
        mod_ph[r.voice] += mstep[31:0];
        thr_ph[r.voice] += tstep[31:0];
      end
    end
  endtask

  // Sampling at the rising edge: prediction, checking, config tracking, watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    sample_t exp_s;
    req_taken <= s_axis_tvalid && s_axis_tready && !rst;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (cfg_we) rate_reg = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        idle_cycles = 0;
        predict_request(cur_req);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        if (expected_samples.size() == 0) begin
          $error("unexpected sample %h", m_axis_tdata);
          failures++;
        end else begin
          exp_s = expected_samples.pop_front();
          if (m_axis_tdata !== exp_s.sample) begin
            $error("sample: expected %h, got %h", exp_s.sample, m_axis_tdata);
            failures++;
          end
          if (m_axis_tlast !== exp_s.last) begin
            $error("last: expected %b, got %b", exp_s.last, m_axis_tlast);
            failures++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Request driver, fed from the pending queue
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst && (req_taken || !s_axis_tvalid)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 12) - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_req = pending_reqs.pop_front();
        s_axis_tdata <= {7'd0, cur_req.count, cur_req.index, cur_req.ratio,
                         cur_req.pitch, cur_req.note, cur_req.voice};
        s_axis_tuser <= cur_req.cmd;
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // Sample receiver with random back-pressure and one long hold-off
  int stall_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk) begin
    if (hold_off_req && !hold_done) begin
      hold_done = 1'b1;
      stall_left = STALL_LEN;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic req_t make_req(input logic [1:0] c, input logic [3:0] v,
                                    input logic [6:0] key, input logic [14:0] bend,
                                    input logic [15:0] ratio, input logic [15:0] depth,
                                    input logic [6:0] cnt);
    req_t r;
    r.cmd = cmd_t'(c);
    r.voice = v;
    r.note = key;
    r.pitch = bend;
    r.ratio = ratio;
    r.index = depth;
    r.count = cnt;
    return r;
  endfunction

  // Mostly note-ons and renders with random content, some resets and junk
  function automatic req_t random_req();
    int sel;
    logic [6:0] cnt, key, raw_cnt;
    logic [3:0] v;
    logic [14:0] bend;
    logic [15:0] ratio, depth;
    sel = $urandom_range(0, 99);
    cnt = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(1, 8));
    v = 4'($urandom);
    key = 7'($urandom);
    bend = 15'($urandom);
    ratio = 16'($urandom);
    depth = 16'($urandom);
    raw_cnt = 7'($urandom);
    if (sel < 4) return make_req(CMD_RESET, v, key, bend, ratio, depth, raw_cnt);
    if (sel < 8) return make_req(CMD_UNUSED, v, key, bend, ratio, depth, raw_cnt);
    if (sel < 35) return make_req(CMD_NOTE_ON, v, key, bend, ratio, depth, raw_cnt);
    return make_req(CMD_RENDER, v, key, bend, ratio, depth, cnt);
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_rate(input logic [17:0] value);
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(random_req());
  endtask

  initial begin
    build_tables();
    foreach (voice_on[i]) voice_on[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes of each field, every command, the ignored cases
    write_rate(18'd8000);
    pending_reqs.push_back(make_req(CMD_RENDER, 4'd3, 7'd60, 15'd0, 16'h1000, 16'h1000,
                                    7'd4));   // inactive voice
    pending_reqs.push_back(make_req(CMD_NOTE_ON, 4'd0, 7'd0, 15'd0, 16'd0, 16'd0, 7'd0));
    pending_reqs.push_back(make_req(CMD_NOTE_ON, 4'd15, 7'd127, 15'h7FFF, 16'hFFFF,
                                    16'hFFFF, 7'h7F));
    pending_reqs.push_back(make_req(CMD_RENDER, 4'd0, 7'd0, 15'h4000, 16'd0, 16'd0, 7'd1));
    pending_reqs.push_back(make_req(CMD_RENDER, 4'd15, 7'd0, 15'h3FFF, 16'hFFFF,
                                    16'hFFFF, 7'd64));
    pending_reqs.push_back(make_req(CMD_RENDER, 4'd15, 7'd0, 15'h5000, 16'h1000,
                                    16'hFFFF, 7'd0));  // zero count
    pending_reqs.push_back(make_req(CMD_RENDER, 4'd0, 7'd0, 15'h3000, 16'h8000,
                                    16'h4000, 7'd127)); // saturated count
    pending_reqs.push_back(make_req(CMD_UNUSED, 4'd0, 7'd64, 15'd0, 16'h1000, 16'h1000,
                                    7'd5));
    pending_reqs.push_back(make_req(CMD_NOTE_ON, 4'd7, 7'd69, 15'd0, 16'd0, 16'd0, 7'd0));
    pending_reqs.push_back(make_req(CMD_RENDER, 4'd7, 7'd0, 15'h7100, 16'h0800,
                                    16'h2000, 7'd3));
    pending_reqs.push_back(make_req(CMD_RESET, 4'd9, 7'd0, 15'd0, 16'd0, 16'd0, 7'd0));
    pending_reqs.push_back(make_req(CMD_RENDER, 4'd7, 7'd0, 15'd0, 16'h1000, 16'h1000,
                                    7'd4));   // cleared voice
    pending_reqs.push_back(make_req(CMD_NOTE_ON, 4'd7, 7'd100, 15'd0, 16'd0, 16'd0, 7'd0));
    pending_reqs.push_back(make_req(CMD_RENDER, 4'd7, 7'd0, 15'h0C00, 16'h3000,
                                    16'h7FFF, 7'd6));
    wait_drained();

    // Rate of 192000, receiver holds off while requests keep coming
    write_rate(18'd192000);
    hold_off_req <= 1'b1;
    for (int v = 0; v < VOICES; v++)
      pending_reqs.push_back(make_req(CMD_NOTE_ON, 4'(v), 7'($urandom), 15'd0, 16'd0,
                                      16'd0, 7'd0));
    queue_random(70);
    wait_drained();

    // Zero rate, then the widest rate value
    write_rate(18'd0);
    pending_reqs.push_back(make_req(CMD_NOTE_ON, 4'd2, 7'd20, 15'd0, 16'd0, 16'd0, 7'd0));
    pending_reqs.push_back(make_req(CMD_RENDER, 4'd2, 7'd0, 15'd0, 16'h1000, 16'h1000,
                                    7'd5));
    wait_drained();
    write_rate(18'h3FFFF);
    queue_random(60);
    wait_drained();

    // Reset rate, no idling on either side
    write_rate(RATE_RESET);
    quiet <= 1'b1;
    queue_random(70);
    wait_drained();

    if (failures == 0 && expected_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
